### src/pca_pkg.sv
// ----------------------------------------------------------------------------
// pca_pkg
// Shared types, constants and the slot selection function of the PWM
// channel allocator.
// ----------------------------------------------------------------------------
package pca_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int NUM_TIMERS   = 4;
  localparam int CH_W         = 4;
  localparam int TMR_W        = 2;
  localparam int FREQ_W       = 27;
  localparam int RES_W        = 5;
  localparam int DUTY_W       = 17;
  localparam int FRAC_W       = 18;
  localparam int Q_BITS       = 16;
  localparam int SW_BASE      = 8;
  localparam int PROD_W       = FREQ_W + Q_BITS + 2;

  localparam logic [FREQ_W-1:0] CLOCK_RESET = FREQ_W'(80000000);
  localparam logic [RES_W-1:0]  MAX_RES     = RES_W'(16);
  localparam logic [DUTY_W-1:0] Q16_ONE     = DUTY_W'(65536);

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_DUTY    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_CHANNEL = 2'd1,
    ST_NOT_IN_USE = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic             load;
    logic             scan;
    logic [TMR_W-1:0] scan_idx;
    logic             pick;
    logic             res_step;
    logic             exec;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic res_done;
  } dp_stat_t;

  typedef struct packed {
    logic            found;
    logic [CH_W-1:0] slot;
  } pick_t;

  // Priority: paired odd slot, then free even slot, then software slot.
  // Lower tiers are evaluated first and overridden by higher ones; within a
  // tier the loop runs downward so the lowest timer wins.
  function automatic pick_t pick_slot(logic [NUM_CHANNELS-1:0] in_use,
                                      logic [NUM_TIMERS-1:0]   match);
    pick_t r;
    r = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (match[i] && !in_use[SW_BASE + 2*i + 1]) begin
        r.found = 1'b1;
        r.slot  = CH_W'(SW_BASE + 2*i + 1);
      end
      if (match[i] && !in_use[SW_BASE + 2*i]) begin
        r.found = 1'b1;
        r.slot  = CH_W'(SW_BASE + 2*i);
      end
    end
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!in_use[2*i]) begin
        r.found = 1'b1;
        r.slot  = CH_W'(2*i);
      end
    end
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (in_use[2*i] && !in_use[2*i + 1] && match[i]) begin
        r.found = 1'b1;
        r.slot  = CH_W'(2*i + 1);
      end
    end
    return r;
  endfunction

endpackage

### src/pca_ctrl.sv
// ----------------------------------------------------------------------------
// pca_ctrl
// Command sequencer: dispatch, timer scan, slot pick, resolution trials,
// execute, result strobe.
// ----------------------------------------------------------------------------
module pca_ctrl
  import pca_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DISP = 6'b000010,
    S_SCAN = 6'b000100,
    S_PICK = 6'b001000,
    S_RES  = 6'b010000,
    S_EXEC = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [TMR_W-1:0] idx_q, idx_d;
  logic             done_q, done_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    cmd_o.scan_idx = idx_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        idx_d = '0;
        if (stat_i.cmd == CMD_ALLOC) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        idx_d      = idx_q + 1'b1;
        if (idx_q == TMR_W'(NUM_TIMERS - 1)) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = S_RES;
      end
      S_RES: begin
        cmd_o.res_step = 1'b1;
        if (stat_i.res_done) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  // result strobes never come on consecutive cycles
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe on consecutive cycles");

  // an accepted item leaves idle at once
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == S_IDLE) |=> state_q == S_DISP)
    else $error("accepted item not dispatched");

  // the scan covers exactly the timers, then the pick follows
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && idx_q == TMR_W'(NUM_TIMERS - 1)) |=> state_q == S_PICK)
    else $error("timer scan did not end in pick");

  // a finished resolution search goes straight to execute
  a_res_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES && stat_i.res_done) |=> (state_q == S_EXEC && !done_q))
    else $error("resolution search exit broken");

endmodule

### src/pca_dp.sv
// ----------------------------------------------------------------------------
// pca_dp
// Datapath: item registers, slot tables, frequency match scan, iterative
// resolution search, duty scaling and result registers.
// ----------------------------------------------------------------------------
module pca_dp
  import pca_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  input  logic                     cfg_we_i,
  input  logic [FREQ_W-1:0]        cfg_data_i,
  input  logic [1:0]               cmd_in_i,
  input  logic [FREQ_W-1:0]        frequency_i,
  input  logic [CH_W-1:0]          channel_i,
  input  logic signed [FRAC_W-1:0] duty_fraction_i,
  output logic [1:0]               status_o,
  output logic [CH_W-1:0]          granted_channel_o,
  output logic [RES_W-1:0]         resolution_bits_o,
  output logic [DUTY_W-1:0]        duty_count_o
);

  // configuration
  logic [FREQ_W-1:0] clk_hz_q;

  // item
  cmd_e                     op_q;
  logic [FREQ_W-1:0]        freq_q;
  logic [CH_W-1:0]          ch_q;
  logic signed [FRAC_W-1:0] frac_q;

  // slot tables
  logic [NUM_CHANNELS-1:0] in_use_q;
  logic [FREQ_W-1:0]       freq_mem_q [NUM_CHANNELS];
  logic [RES_W-1:0]        res_mem_q  [NUM_CHANNELS];

  // search
  logic [NUM_TIMERS-1:0] match_q;
  pick_t                 pick_q;
  logic [PROD_W-1:0]     mult_q;   // freq << p
  logic [RES_W-1:0]      p_q;
  logic [RES_W-1:0]      res_q;

  // results
  logic [1:0]        status_q;
  logic [CH_W-1:0]   granted_q;
  logic [RES_W-1:0]  resbits_q;
  logic [DUTY_W-1:0] duty_q;

  // scan read of even slot frequencies
  logic [CH_W-1:0]   scan_addr;
  logic              scan_eq;
  assign scan_addr = {cmd_i.scan_idx, 1'b0};
  assign scan_eq   = (freq_mem_q[scan_addr] == freq_q);

  // resolution trial: floor(clk/f) <= 2^p  <=>  clk < (2^p + 1) * f
  logic              freq_zero;
  logic              trial_ok;
  logic [RES_W-1:0]  res_val;
  assign freq_zero = (freq_q == '0);
  assign trial_ok  = ({{(PROD_W-FREQ_W){1'b0}}, clk_hz_q})
                     < (mult_q + {{(PROD_W-FREQ_W){1'b0}}, freq_q});

  always_comb begin
    if (freq_zero) begin
      res_val = (clk_hz_q != '0) ? MAX_RES : '0;
    end else if (trial_ok) begin
      res_val = (p_q == '0) ? '0 : p_q - 1'b1;
    end else begin
      res_val = MAX_RES;
    end
  end

  assign stat_o.cmd      = op_q;
  assign stat_o.res_done = !pick_q.found || freq_zero || trial_ok || (p_q == MAX_RES);

  // duty scaling for the addressed channel
  logic [RES_W-1:0]    rd_res;
  logic [DUTY_W-1:0]   frac_clamp;
  logic [2*DUTY_W-1:0] frac_shift;
  assign rd_res = res_mem_q[ch_q];

  always_comb begin
    if (frac_q[FRAC_W-1]) begin
      frac_clamp = '0;
    end else if (frac_q[FRAC_W-2:0] > Q16_ONE) begin
      frac_clamp = Q16_ONE;
    end else begin
      frac_clamp = frac_q[FRAC_W-2:0];
    end
  end

  assign frac_shift = {{DUTY_W{1'b0}}, frac_clamp} << rd_res;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= CLOCK_RESET;
      in_use_q <= '0;
    end else begin
      if (cfg_we_i) begin
        clk_hz_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        case (op_q)
          CMD_ALLOC: begin
            if (pick_q.found) begin
              in_use_q[pick_q.slot] <= 1'b1;
            end
          end
          CMD_RELEASE: begin
            in_use_q[ch_q] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= cmd_e'(cmd_in_i);
      freq_q <= frequency_i;
      ch_q   <= channel_i;
      frac_q <= duty_fraction_i;
    end
    if (cmd_i.scan) begin
      match_q[cmd_i.scan_idx] <= scan_eq;
    end
    if (cmd_i.pick) begin
      pick_q <= pick_slot(in_use_q, match_q);
      mult_q <= {{(PROD_W-FREQ_W){1'b0}}, freq_q};
      p_q    <= '0;
    end
    if (cmd_i.res_step) begin
      if (stat_o.res_done) begin
        res_q <= res_val;
      end else begin
        mult_q <= {mult_q[PROD_W-2:0], 1'b0};
        p_q    <= p_q + 1'b1;
      end
    end
    if (cmd_i.exec) begin
      status_q  <= ST_OK;
      granted_q <= ch_q;
      resbits_q <= '0;
      duty_q    <= '0;
      case (op_q)
        CMD_ALLOC: begin
          if (pick_q.found) begin
            freq_mem_q[pick_q.slot] <= freq_q;
            res_mem_q[pick_q.slot]  <= res_q;
            granted_q <= pick_q.slot;
            resbits_q <= res_q;
          end else begin
            status_q  <= ST_NO_CHANNEL;
            granted_q <= '0;
          end
        end
        CMD_RELEASE: begin
          if (in_use_q[ch_q]) begin
            resbits_q <= rd_res;
          end else begin
            status_q <= ST_NOT_IN_USE;
          end
        end
        CMD_DUTY: begin
          if (in_use_q[ch_q]) begin
            resbits_q <= rd_res;
            duty_q    <= frac_shift[DUTY_W+Q_BITS-1:Q_BITS];
          end else begin
            status_q <= ST_NOT_IN_USE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign status_o          = status_q;
  assign granted_channel_o = granted_q;
  assign resolution_bits_o = resbits_q;
  assign duty_count_o      = duty_q;

endmodule

### src/pwm_channel_allocator.sv
// ----------------------------------------------------------------------------
// pwm_channel_allocator
// Allocates 16 PWM channels on 4 shared timers, frees them and turns Q16
// duty fractions into compare counts.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low; exactly one
// result follows, shown for a single cycle with done_o high, and it must be
// captured then: there is no way to hold it. Allocate goes through a
// dispatch state, a scan comparing the frequency with each of the four
// timers' even slots, a pick state, one to seventeen resolution trials
// (one shift-add-compare per cycle, stopping at the first power of two
// that covers the clock/frequency period) and an execute state. Release,
// duty and the no-op command go from dispatch to execute. busy_o drops in the
// cycle that carries the strobe, so the next item may be accepted there.
// Write source_clock_hz through cfg_valid_i / cfg_data_i only while no item
// is pending; cfg_ready_o is always high. There is no clearing pass after
// reset: only occupancy bits and the clock setting are reset. The resolution
// table is used for occupied slots only; the scan reads all even slots.
// ----------------------------------------------------------------------------
module pwm_channel_allocator
  import pca_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command channel
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               cmd_i,
  input  logic [FREQ_W-1:0]        frequency_i,
  input  logic [CH_W-1:0]          channel_i,
  input  logic signed [FRAC_W-1:0] duty_fraction_i,
  // result
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [CH_W-1:0]          granted_channel_o,
  output logic [RES_W-1:0]         resolution_bits_o,
  output logic [DUTY_W-1:0]        duty_count_o,
  // configuration: source_clock_hz
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [FREQ_W-1:0]        cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  // sequencer
  pca_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (dp_stat),
    .cmd_o   (dp_cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // tables, search and result registers
  pca_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .cfg_we_i          (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_in_i          (cmd_i),
    .frequency_i       (frequency_i),
    .channel_i         (channel_i),
    .duty_fraction_i   (duty_fraction_i),
    .status_o          (status_o),
    .granted_channel_o (granted_channel_o),
    .resolution_bits_o (resolution_bits_o),
    .duty_count_o      (duty_count_o)
  );

endmodule
